[rtl/read_coverage_accumulator_defines.svh]
// Assertion macros for the read coverage accumulator checker.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef READ_COVERAGE_ACCUMULATOR_DEFINES_SVH
`define READ_COVERAGE_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define RCA_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("read coverage accumulator check failed");

// Next-cycle implication, off while reset is high.
`define RCA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("read coverage accumulator check failed");

`endif

[rtl/rca_pkg.sv]
// Shared constants, codes and controller/datapath types of the read coverage accumulator.
// No dependencies; the interfaces, controller, datapath, top level and checker import it.
package rca_pkg;

   localparam int MAX_POSITIONS = 1048576;
   localparam int ADDR_W        = $clog2(MAX_POSITIONS);
   localparam int POS_W         = 21;   // read_start, read_end, reference_length
   localparam int QPOS_W        = 20;
   localparam int CLIP_W        = 28;
   localparam int CNT_W         = 31;
   localparam int FUNC_W        = 2;

   localparam logic [POS_W-1:0] LEN_RESET = POS_W'(1048576);
   localparam logic [POS_W-1:0] LEN_CAP   = POS_W'(MAX_POSITIONS);
   localparam logic [CNT_W-1:0] CNT_MAX   = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_QUERY = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_WALK,
      ST_LEAD_RD,
      ST_LEAD_WR,
      ST_TAIL_RD,
      ST_TAIL_WR,
      ST_QRY_RD,
      ST_QRY_OUT
   } state_type;

   typedef struct packed {
      logic ready;      // take an item this cycle if one is offered
      logic clr_start;  // restart the clearing sweep and zero the primary count
      logic clr_step;   // zero one entry of both stores
      logic walk_init;  // set up the depth walk of the held read
      logic walk_step;  // one position of the depth walk
      logic clip_rd;    // read the clip store at the read start or end
      logic clip_wr;    // write back the clip sum
      logic clip_tail;  // selects read end and trailing clip length
      logic qry_rd;     // read both stores at the query position
      logic qry_out;    // load the result register
   } cmd_type;

   typedef struct packed {
      logic              req_valid;
      logic [FUNC_W-1:0] func;
      logic              mapped;
      logic              walk_done;
      logic              lead_ok;
      logic              tail_ok;
      logic              clr_last;
      logic              rsp_busy;
   } status_type;

endpackage

[rtl/rca_req_if.sv]
// Input item channel of the read coverage accumulator: valid/ready plus read fields.
// Depends on rca_pkg.
interface rca_req_if;
   import rca_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [POS_W-1:0]    read_start;
   logic [POS_W-1:0]    read_end;
   logic                is_mapped;
   logic                is_primary;
   logic                lead_is_clip;
   logic [CLIP_W-1:0]   lead_clip_length;
   logic                tail_is_clip;
   logic [CLIP_W-1:0]   tail_clip_length;
   logic [QPOS_W-1:0]   query_position;

   modport source (
      output valid, func, read_start, read_end, is_mapped, is_primary,
             lead_is_clip, lead_clip_length, tail_is_clip, tail_clip_length,
             query_position,
      input  ready
   );

   modport sink (
      input  valid, func, read_start, read_end, is_mapped, is_primary,
             lead_is_clip, lead_clip_length, tail_is_clip, tail_clip_length,
             query_position,
      output ready
   );

endinterface

[rtl/rca_rsp_if.sv]
// Result item channel of the read coverage accumulator: valid/ready plus query result.
// Depends on rca_pkg.
interface rca_rsp_if;
   import rca_pkg::*;

   logic               valid;
   logic               ready;
   logic [CNT_W-1:0]   depth_count;
   logic [CNT_W-1:0]   clip_sum;
   logic [CNT_W-1:0]   primary_reads;
   logic               out_of_range;

   modport source (
      output valid, depth_count, clip_sum, primary_reads, out_of_range,
      input  ready
   );

   modport sink (
      input  valid, depth_count, clip_sum, primary_reads, out_of_range,
      output ready
   );

endinterface

[rtl/rca_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rca_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/rca_ctrl.sv]
// Controller state machine of the read coverage accumulator.
// Depends on rca_pkg; drives rca_dp through cmd_type and reads status_type.
module rca_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  rca_pkg::status_type status,
   output rca_pkg::cmd_type    cmd
);
   import rca_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (status.req_valid) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.func)
               FUNC_ADD: begin
                  if (status.mapped) begin
                     cmd.walk_init = 1'b1;
                     state_in      = ST_WALK;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
               FUNC_QUERY: begin
                  state_in = ST_QRY_RD;
               end
               FUNC_CLEAR: begin
                  cmd.clr_start = 1'b1;
                  state_in      = ST_CLEAR;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_WALK: begin
            // last pending depth write retires in the cycle walk_done is seen
            cmd.walk_step = 1'b1;
            if (status.walk_done) begin
               if (status.lead_ok) begin
                  state_in = ST_LEAD_RD;
               end else if (status.tail_ok) begin
                  state_in = ST_TAIL_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_LEAD_RD: begin
            cmd.clip_rd = 1'b1;
            state_in    = ST_LEAD_WR;
         end
         ST_LEAD_WR: begin
            cmd.clip_wr = 1'b1;
            state_in    = status.tail_ok ? ST_TAIL_RD : ST_IDLE;
         end
         ST_TAIL_RD: begin
            cmd.clip_rd   = 1'b1;
            cmd.clip_tail = 1'b1;
            state_in      = ST_TAIL_WR;
         end
         ST_TAIL_WR: begin
            cmd.clip_wr   = 1'b1;
            cmd.clip_tail = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_QRY_RD: begin
            cmd.qry_rd = 1'b1;
            state_in   = ST_QRY_OUT;
         end
         ST_QRY_OUT: begin
            if (!status.rsp_busy) begin
               cmd.qry_out = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

[rtl/rca_dp.sv]
// Datapath of the read coverage accumulator: item hold, depth walk, clip update,
// clearing sweep, primary count and result register. Depends on rca_pkg, rca_ram,
// rca_req_if and rca_rsp_if.
module rca_dp (
   input  logic                      clock,
   input  logic                      reset,
   rca_req_if.sink                   req_ch,
   rca_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [rca_pkg::POS_W-1:0] csr_wr_data,
   input  rca_pkg::cmd_type          cmd,
   output rca_pkg::status_type       status
);
   import rca_pkg::*;

   // held item
   logic [FUNC_W-1:0] func_ff;
   logic [POS_W-1:0]  rs_ff;
   logic [POS_W-1:0]  re_ff;
   logic              mapped_ff;
   logic              primary_flag_ff;
   logic              lead_clip_ff;
   logic [CLIP_W-1:0] lead_len_ff;
   logic              tail_clip_ff;
   logic [CLIP_W-1:0] tail_len_ff;
   logic [QPOS_W-1:0] qpos_ff;

   logic [POS_W-1:0]  csr_len_ff;
   logic [POS_W-1:0]  len_eff;

   // depth walk
   logic [POS_W-1:0]  cur_ff;
   logic [POS_W-1:0]  cur_in;
   logic [POS_W-1:0]  hi_ff;
   logic [POS_W-1:0]  hi_in;
   logic              pend_ff;
   logic              pend_in;
   logic [ADDR_W-1:0] pend_addr_ff;
   logic              cur_lt_hi;
   logic [POS_W-1:0]  min_pos;
   logic [POS_W-1:0]  max_pos;

   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [ADDR_W-1:0] clr_cnt_in;
   logic [CNT_W-1:0]  primary_ff;
   logic [CNT_W-1:0]  primary_in;

   // store ports
   logic              depth_we;
   logic [ADDR_W-1:0] depth_waddr;
   logic [CNT_W-1:0]  depth_wdata;
   logic              depth_re;
   logic [ADDR_W-1:0] depth_raddr;
   logic [CNT_W-1:0]  depth_rd;
   logic              clip_we;
   logic [ADDR_W-1:0] clip_waddr;
   logic [CNT_W-1:0]  clip_wdata;
   logic              clip_re;
   logic [ADDR_W-1:0] clip_raddr;
   logic [CNT_W-1:0]  clip_rd;
   logic [ADDR_W-1:0] clip_pos;
   logic [CLIP_W-1:0] clip_len;
   logic [CNT_W:0]    clip_sum_wide;

   // result register
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [CNT_W-1:0]  rsp_depth_ff;
   logic [CNT_W-1:0]  rsp_clip_ff;
   logic [CNT_W-1:0]  rsp_primary_ff;
   logic              rsp_oor_ff;
   logic              qry_oor;

   logic              load;

   assign load         = req_ch.valid && cmd.ready;
   assign req_ch.ready = cmd.ready;

   always_ff @(posedge clock) begin
      if (load) begin
         func_ff         <= req_ch.func;
         rs_ff           <= req_ch.read_start;
         re_ff           <= req_ch.read_end;
         mapped_ff       <= req_ch.is_mapped;
         primary_flag_ff <= req_ch.is_primary;
         lead_clip_ff    <= req_ch.lead_is_clip;
         lead_len_ff     <= req_ch.lead_clip_length;
         tail_clip_ff    <= req_ch.tail_is_clip;
         tail_len_ff     <= req_ch.tail_clip_length;
         qpos_ff         <= req_ch.query_position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_len_ff <= LEN_RESET;
      end else if (csr_wr_en) begin
         csr_len_ff <= csr_wr_data;
      end
   end

   assign len_eff = (csr_len_ff > LEN_CAP) ? LEN_CAP : csr_len_ff;

   // depth walk bounds: [min(start,end)-1 clamped, min(max(start,end), length))
   assign min_pos   = (rs_ff < re_ff) ? rs_ff : re_ff;
   assign max_pos   = (rs_ff > re_ff) ? rs_ff : re_ff;
   assign cur_lt_hi = cur_ff < hi_ff;

   always_comb begin
      cur_in = cur_ff;
      hi_in  = hi_ff;
      if (cmd.walk_init) begin
         cur_in = (min_pos == '0) ? '0 : min_pos - POS_W'(1);
         hi_in  = (max_pos > len_eff) ? len_eff : max_pos;
      end else if (cmd.walk_step && cur_lt_hi) begin
         cur_in = cur_ff + POS_W'(1);
      end
   end

   assign pend_in = cmd.walk_step && cur_lt_hi;

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      hi_ff        <= hi_in;
      pend_addr_ff <= cur_ff[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // clearing sweep and primary count
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      primary_in = primary_ff;
      if (cmd.clr_start) begin
         clr_cnt_in = '0;
         primary_in = '0;
      end else if (cmd.clr_step) begin
         clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
      end
      if (cmd.walk_init && primary_flag_ff && primary_ff != CNT_MAX) begin
         primary_in = primary_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
         primary_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         primary_ff <= primary_in;
      end
   end

   // depth store: read at the walk position, write back one position behind; query reads, sweep clears
   assign depth_re    = (cmd.walk_step && cur_lt_hi) || cmd.qry_rd;
   assign depth_raddr = cmd.qry_rd ? ADDR_W'(qpos_ff) : cur_ff[ADDR_W-1:0];
   assign depth_we    = cmd.clr_step || pend_ff;
   assign depth_waddr = cmd.clr_step ? clr_cnt_ff : pend_addr_ff;
   assign depth_wdata = cmd.clr_step ? '0 :
                        (depth_rd == CNT_MAX) ? CNT_MAX : depth_rd + CNT_W'(1);

   // clip store: read-modify-write at read start or read end; query reads, sweep clears
   assign clip_pos      = cmd.clip_tail ? re_ff[ADDR_W-1:0] : rs_ff[ADDR_W-1:0];
   assign clip_len      = cmd.clip_tail ? tail_len_ff : lead_len_ff;
   assign clip_sum_wide = {1'b0, clip_rd} + (CNT_W+1)'(clip_len);
   assign clip_re       = cmd.clip_rd || cmd.qry_rd;
   assign clip_raddr    = cmd.qry_rd ? ADDR_W'(qpos_ff) : clip_pos;
   assign clip_we       = cmd.clr_step || cmd.clip_wr;
   assign clip_waddr    = cmd.clr_step ? clr_cnt_ff : clip_pos;
   assign clip_wdata    = cmd.clr_step ? '0 :
                          clip_sum_wide[CNT_W] ? CNT_MAX : clip_sum_wide[CNT_W-1:0];

   rca_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_POSITIONS)
   ) u_depth_ram (
      .clock   (clock),
      .wr_en   (depth_we),
      .wr_addr (depth_waddr),
      .wr_data (depth_wdata),
      .rd_en   (depth_re),
      .rd_addr (depth_raddr),
      .rd_data (depth_rd)
   );

   rca_ram #(
      .WIDTH (CNT_W),
      .DEPTH (MAX_POSITIONS)
   ) u_clip_ram (
      .clock   (clock),
      .wr_en   (clip_we),
      .wr_addr (clip_waddr),
      .wr_data (clip_wdata),
      .rd_en   (clip_re),
      .rd_addr (clip_raddr),
      .rd_data (clip_rd)
   );

   // result register
   assign qry_oor = !(POS_W'(qpos_ff) < len_eff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.qry_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.qry_out) begin
         rsp_depth_ff   <= qry_oor ? '0 : depth_rd;
         rsp_clip_ff    <= qry_oor ? '0 : clip_rd;
         rsp_primary_ff <= primary_ff;
         rsp_oor_ff     <= qry_oor;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.depth_count   = rsp_depth_ff;
   assign rsp_ch.clip_sum      = rsp_clip_ff;
   assign rsp_ch.primary_reads = rsp_primary_ff;
   assign rsp_ch.out_of_range  = rsp_oor_ff;

   always_comb begin
      status.req_valid = req_ch.valid;
      status.func      = func_ff;
      status.mapped    = mapped_ff;
      status.walk_done = !cur_lt_hi;
      status.lead_ok   = lead_clip_ff && (rs_ff < len_eff);
      status.tail_ok   = tail_clip_ff && (re_ff < len_eff);
      status.clr_last  = clr_cnt_ff == '1;
      status.rsp_busy  = rsp_valid_ff && !rsp_ch.ready;
   end

endmodule

[rtl/read_coverage_accumulator.sv]
// Channel   Dir  Handshake       Payload
// req_ch    in   valid/ready     func, read span, flags, clip lengths, query_position
// rsp_ch    out  valid/ready     depth_count, clip_sum, primary_reads, out_of_range
// csr       in   csr_wr_en       csr_wr_data = reference_length
//
// Add read: the depth store takes one read-modify-write per covered position;
//   then each soft clip inside the reference gets one on the clip store.
// Query: waits in place while the previous result is still held.
// Clear item and reset: a sweep zeroes all 1048576 entries of both stores, no item taken.
// Add, clear and unused codes return no item.
// Top level of the read coverage accumulator; depends on rca_pkg, the channel
// interfaces, rca_ctrl and rca_dp.
module read_coverage_accumulator (
   input  logic                      clock,
   input  logic                      reset,
   rca_req_if.sink                   req_ch,
   rca_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [rca_pkg::POS_W-1:0] csr_wr_data
);
   import rca_pkg::*;

   cmd_type    cmd;
   status_type status;

   rca_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   rca_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

[rtl/rca_checker.sv]
// Port-level checks of the read coverage accumulator, bound to the top level.
// Depends on rca_pkg and read_coverage_accumulator_defines.svh.
`include "read_coverage_accumulator_defines.svh"

module rca_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [rca_pkg::CNT_W-1:0] rsp_depth_count,
   input logic [rca_pkg::CNT_W-1:0] rsp_clip_sum,
   input logic [rca_pkg::CNT_W-1:0] rsp_primary_reads,
   input logic                      rsp_out_of_range
);
   import rca_pkg::*;

   // a held result does not change until taken
   `RCA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_depth_count) && $stable(rsp_clip_sum) && $stable(rsp_primary_reads) && $stable(rsp_out_of_range))

   // positions past the reference report no depth and no clips
   `RCA_ASSERT_NOW(a_oor_zero, rsp_valid && rsp_out_of_range, rsp_depth_count == '0 && rsp_clip_sum == '0)

   // one item at a time: never accepts in back-to-back cycles
   `RCA_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)

   // clearing sweep runs right after reset
   `RCA_ASSERT_NOW(a_sweep_after_reset, $fell(reset), !req_ready)

endmodule

bind read_coverage_accumulator rca_checker u_rca_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_depth_count   (rsp_ch.depth_count),
   .rsp_clip_sum      (rsp_ch.clip_sum),
   .rsp_primary_reads (rsp_ch.primary_reads),
   .rsp_out_of_range  (rsp_ch.out_of_range)
);
